// ===== sv/degree_day_snow_cell_update_defines.svh =====
// ---------------------------------------------------------------------------
// degree_day_snow_cell_update assertion macros
// Shared concurrent assertion forms, clocked on i_clk, off while in reset.
// ---------------------------------------------------------------------------
`ifndef DEGREE_DAY_SNOW_CELL_UPDATE_DEFINES_SVH
`define DEGREE_DAY_SNOW_CELL_UPDATE_DEFINES_SVH

// same-cycle implication
`define DDSC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DDSC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/ddsc_pkg.sv =====
// ---------------------------------------------------------------------------
// ddsc_pkg
// Field widths, configuration layout and the snowpack write bundle.
// ---------------------------------------------------------------------------
package ddsc_pkg;

    localparam int CELL_W    = 12;
    localparam int TEMP_W    = 16;
    localparam int PRECIP_W  = 24;
    localparam int WATER_W   = 32;
    localparam int FRAC_W    = 17;
    localparam int FACTOR_W  = 16;
    localparam int CFG_IDX_W = 3;

    // Q1.16 one
    localparam logic [FRAC_W-1:0] FRAC_ONE = 17'h10000;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SNOW_FRAC   = 3'd0,
        CFG_SNOW_FACTOR = 3'd1,
        CFG_RAIN_FACTOR = 3'd2,
        CFG_MELT_BASE   = 3'd3,
        CFG_SNOWFALL    = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [FRAC_W-1:0]          snow_fraction;    // already clamped to one
        logic [FACTOR_W-1:0]        snow_melt_factor;
        logic [FACTOR_W-1:0]        rain_melt_factor;
        logic signed [TEMP_W-1:0]   melt_base_temp;
        logic signed [TEMP_W-1:0]   snowfall_temp;
    } t_cfg;

    // snowpack write-back from the last stage
    typedef struct packed {
        logic               en;
        logic [CELL_W-1:0]  cell_id;
        logic [WATER_W-1:0] data;
    } t_wr;

endpackage

// ===== sv/degree_day_snow_cell_update.sv =====
// Accepted items pass through pipeline stages 1-4 and then the output register to reach the output.
// Throughput: one item per cycle unless the output or the clearing sweep stalls; the snowpack
//   memory's single read and single write port carry one read-modify-write per cycle, with forwarding.
// Reset: synchronous, active low. Valid bits and config registers reset to zero,
//   then a clearing sweep zeroes every entry of the snowpack memory while
//   o_in_stall is high.
// ---------------------------------------------------------------------------
// degree_day_snow_cell_update
// Degree-day snow accumulation and melt per grid cell, with a per-cell
// snowpack held in on-chip memory.
// ---------------------------------------------------------------------------
`include "degree_day_snow_cell_update_defines.svh"

module degree_day_snow_cell_update import ddsc_pkg::*; #(
    parameter int CELLS = 4096
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // configuration
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [FRAC_W-1:0]         i_cfg_data,
    // item input
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [CELL_W-1:0]         i_cell_req,
    input  logic signed [TEMP_W-1:0]  i_air_temp,
    input  logic [PRECIP_W-1:0]       i_net_precip,
    // result output
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [CELL_W-1:0]         o_cell_out,
    output logic [WATER_W-1:0]        o_snow_melt,
    output logic [WATER_W-1:0]        o_snowpack,
    output logic [WATER_W-1:0]        o_precip_out
);

    t_cfg               r_cfg;
    t_wr                w_wr;
    logic               w_clr_busy;
    logic               w_ready;
    logic               w_acc;
    logic [WATER_W-1:0] w_rd_data;

    // configuration registers; the snow share is clamped to one on write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SNOW_FRAC:   r_cfg.snow_fraction <=
                                     (i_cfg_data > FRAC_ONE) ? FRAC_ONE : i_cfg_data;
                CFG_SNOW_FACTOR: r_cfg.snow_melt_factor <= i_cfg_data[FACTOR_W-1:0];
                CFG_RAIN_FACTOR: r_cfg.rain_melt_factor <= i_cfg_data[FACTOR_W-1:0];
                CFG_MELT_BASE:   r_cfg.melt_base_temp   <= i_cfg_data[TEMP_W-1:0];
                CFG_SNOWFALL:    r_cfg.snowfall_temp    <= i_cfg_data[TEMP_W-1:0];
                default: ;
            endcase
        end
    end

    // input handshake
    assign o_in_stall = w_clr_busy || !w_ready;
    assign w_acc      = i_in_valid && !o_in_stall;

    ddsc_store #(
        .CELLS (CELLS)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_acc),
        .i_rd_cell (i_cell_req),
        .o_rd_data (w_rd_data),
        .i_wr      (w_wr),
        .o_busy    (w_clr_busy)
    );

    ddsc_pipe #(
        .CELLS (CELLS)
    ) u_pipe (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_acc        (w_acc),
        .i_cell_req   (i_cell_req),
        .i_air_temp   (i_air_temp),
        .i_net_precip (i_net_precip),
        .i_rd_data    (w_rd_data),
        .i_out_stall  (i_out_stall),
        .o_ready      (w_ready),
        .o_wr         (w_wr),
        .o_out_valid  (o_out_valid),
        .o_cell_out   (o_cell_out),
        .o_snow_melt  (o_snow_melt),
        .o_snowpack   (o_snowpack),
        .o_precip_out (o_precip_out)
    );

    // every write-back shows up as the next result
    `DDSC_ASSERT_NEXT(a_wr_matches_out, w_wr.en, o_out_valid && o_cell_out == $past(w_wr.cell_id) && o_snowpack == $past(w_wr.data), "write-back does not match result")
    // melt always reaches the water passed on
    `DDSC_ASSERT_NOW(a_melt_in_water, o_out_valid && o_snow_melt != '0, o_precip_out >= o_snow_melt, "melt larger than water out")
    // nothing moves while the memory is being cleared
    `DDSC_ASSERT_NOW(a_clear_quiet, w_clr_busy, !o_out_valid && !w_wr.en, "activity during clearing sweep")

endmodule

// ===== sv/ddsc_store.sv =====
// ---------------------------------------------------------------------------
// ddsc_store
// Per-cell snowpack memory: one write port, one registered read port, and a
// clearing sweep after reset that zeroes every entry.
// ---------------------------------------------------------------------------
module ddsc_store import ddsc_pkg::*; #(
    parameter int CELLS = 4096
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_rd_en,
    input  logic [CELL_W-1:0]  i_rd_cell,
    output logic [WATER_W-1:0] o_rd_data,
    input  t_wr                i_wr,
    output logic               o_busy
);

    localparam int AW = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam logic [AW-1:0] LAST = AW'(CELLS - 1);

    logic [WATER_W-1:0] mem [CELLS];
    logic [WATER_W-1:0] r_rd_data;
    logic               r_clr_busy;
    logic [AW-1:0]      r_clr_addr;

    // clearing sweep control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == LAST) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // write port: sweep has priority, no items flow meanwhile
    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            mem[r_clr_addr] <= '0;
        end else if (i_wr.en) begin
            mem[AW'(i_wr.cell_id)] <= i_wr.data;
        end
    end

    // registered read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[AW'(i_rd_cell)];
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_busy    = r_clr_busy;

endmodule

// ===== sv/ddsc_pipe.sv =====
// ---------------------------------------------------------------------------
// ddsc_pipe
// Four-stage update pipeline plus output register. Products are formed in
// stages 1-3, the snowpack is resolved and written back in stage 4. Pending
// writes are forwarded into every stage that holds the same cell.
// ---------------------------------------------------------------------------
module ddsc_pipe import ddsc_pkg::*; #(
    parameter int CELLS = 4096
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_cfg                      i_cfg,
    input  logic                      i_acc,
    input  logic [CELL_W-1:0]         i_cell_req,
    input  logic signed [TEMP_W-1:0]  i_air_temp,
    input  logic [PRECIP_W-1:0]       i_net_precip,
    input  logic [WATER_W-1:0]        i_rd_data,
    input  logic                      i_out_stall,
    output logic                      o_ready,
    output t_wr                       o_wr,
    output logic                      o_out_valid,
    output logic [CELL_W-1:0]         o_cell_out,
    output logic [WATER_W-1:0]        o_snow_melt,
    output logic [WATER_W-1:0]        o_snowpack,
    output logic [WATER_W-1:0]        o_precip_out
);

    localparam int P1_W  = FACTOR_W + PRECIP_W;      // rain factor x precip
    localparam int Q_W   = 2 * FACTOR_W;             // snow factor x dT
    localparam int R2_W  = P1_W + TEMP_W;            // rain term x dT
    localparam int SUM_W = R2_W + 1;
    localparam int M_W   = SUM_W - 24;               // melt before clamp
    localparam int ST_W  = PRECIP_W + FRAC_W;

    // stage valids and flow
    logic r_v1, r_v2, r_v3, r_v4, r_ov;
    logic free1, free2, free3, free4, free_o;
    logic mv1, mv2, mv3, mv4;

    // stage 1
    logic [CELL_W-1:0]   r_cell1;
    logic                r_inr1, r_cold1, r_warm1;
    logic [PRECIP_W-1:0] r_precip1;
    logic [TEMP_W-1:0]   r_d1;
    logic                r_f1;
    logic [WATER_W-1:0]  r_fv1;
    // stage 2
    logic [CELL_W-1:0]   r_cell2;
    logic                r_inr2, r_cold2, r_warm2;
    logic [PRECIP_W-1:0] r_precip2;
    logic [TEMP_W-1:0]   r_d2;
    logic [WATER_W-1:0]  r_pack2;
    logic [P1_W-1:0]     r_p1_2;
    logic [Q_W-1:0]      r_q2;
    logic [PRECIP_W-1:0] r_stored2;
    // stage 3
    logic [CELL_W-1:0]   r_cell3;
    logic                r_inr3, r_cold3, r_warm3;
    logic [PRECIP_W-1:0] r_precip3;
    logic [WATER_W-1:0]  r_pack3;
    logic [Q_W-1:0]      r_q3;
    logic [R2_W-1:0]     r_r2_3;
    logic [PRECIP_W-1:0] r_stored3;
    // stage 4
    logic [CELL_W-1:0]   r_cell4;
    logic                r_inr4, r_cold4, r_warm4;
    logic [PRECIP_W-1:0] r_precip4;
    logic [WATER_W-1:0]  r_pack4;
    logic [M_W-1:0]      r_msum4;
    logic [PRECIP_W-1:0] r_stored4;
    // output register
    logic [CELL_W-1:0]   r_o_cell;
    logic [WATER_W-1:0]  r_o_melt, r_o_pack, r_o_water;

    // combinational
    logic                inr_in, cold_in, hit_in;
    logic [TEMP_W:0]     dt_in;
    logic [WATER_W-1:0]  pack1;
    logic                hit1, hit2, hit3;
    logic [P1_W-1:0]     p1;
    logic [Q_W-1:0]      q;
    logic [ST_W-1:0]     st_full;
    logic [SUM_W-1:0]    msum;
    logic [WATER_W:0]    sum_c, sum_w;
    logic [WATER_W-1:0]  melt_c, pack_new, melt_new, water_new;
    logic [M_W-1:0]      pack_ext;

    // ready chain from the output back
    always_comb begin
        free_o  = !r_ov || !i_out_stall;
        mv4     = r_v4 && free_o;
        free4   = !r_v4 || mv4;
        mv3     = r_v3 && free4;
        free3   = !r_v3 || mv3;
        mv2     = r_v2 && free3;
        free2   = !r_v2 || mv2;
        mv1     = r_v1 && free2;
        free1   = !r_v1 || mv1;
    end
    assign o_ready = free1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (free1)  r_v1 <= i_acc;
            if (free2)  r_v2 <= r_v1;
            if (free3)  r_v3 <= r_v2;
            if (free4)  r_v4 <= r_v3;
            if (free_o) r_ov <= r_v4;
        end
    end

    // input decode: range, dT, cold flag, same-edge write hit
    always_comb begin
        inr_in  = (32'(i_cell_req) < 32'(CELLS));
        dt_in   = {i_air_temp[TEMP_W-1], i_air_temp}
                - {i_cfg.melt_base_temp[TEMP_W-1], i_cfg.melt_base_temp};
        cold_in = ($signed(i_air_temp) < $signed(i_cfg.snowfall_temp));
        hit_in  = o_wr.en && inr_in && (i_cell_req == o_wr.cell_id);
    end

    // forwarding hits against the write leaving stage 4
    always_comb begin
        hit1  = o_wr.en && r_v1 && r_inr1 && (r_cell1 == o_wr.cell_id);
        hit2  = o_wr.en && r_v2 && r_inr2 && (r_cell2 == o_wr.cell_id);
        hit3  = o_wr.en && r_v3 && r_inr3 && (r_cell3 == o_wr.cell_id);
        pack1 = !r_inr1 ? '0 : (r_f1 ? r_fv1 : i_rd_data);
    end

    // stage 1: capture item, read issued in parallel
    always_ff @(posedge i_clk) begin
        if (i_acc) begin
            r_cell1   <= i_cell_req;
            r_inr1    <= inr_in;
            r_cold1   <= cold_in;
            r_warm1   <= !dt_in[TEMP_W];
            r_d1      <= dt_in[TEMP_W-1:0];
            r_precip1 <= i_net_precip;
            r_f1      <= hit_in;
            r_fv1     <= o_wr.data;
        end else if (hit1) begin
            r_f1      <= 1'b1;
            r_fv1     <= o_wr.data;
        end
    end

    // first products
    always_comb begin
        p1      = {{(P1_W-FACTOR_W){1'b0}}, i_cfg.rain_melt_factor}
                * {{(P1_W-PRECIP_W){1'b0}}, r_precip1};
        q       = {{(Q_W-FACTOR_W){1'b0}}, i_cfg.snow_melt_factor}
                * {{(Q_W-TEMP_W){1'b0}}, r_d1};
        st_full = {{(ST_W-PRECIP_W){1'b0}}, r_precip1}
                * {{(ST_W-FRAC_W){1'b0}}, i_cfg.snow_fraction};
    end

    // stage 2
    always_ff @(posedge i_clk) begin
        if (mv1) begin
            r_cell2   <= r_cell1;
            r_inr2    <= r_inr1;
            r_cold2   <= r_cold1;
            r_warm2   <= r_warm1;
            r_d2      <= r_d1;
            r_precip2 <= r_precip1;
            r_pack2   <= hit1 ? o_wr.data : pack1;
            r_p1_2    <= p1;
            r_q2      <= q;
            r_stored2 <= st_full[16 +: PRECIP_W];
        end else if (hit2) begin
            r_pack2   <= o_wr.data;
        end
    end

    // stage 3: rain term times dT
    always_ff @(posedge i_clk) begin
        if (mv2) begin
            r_cell3   <= r_cell2;
            r_inr3    <= r_inr2;
            r_cold3   <= r_cold2;
            r_warm3   <= r_warm2;
            r_precip3 <= r_precip2;
            r_pack3   <= hit2 ? o_wr.data : r_pack2;
            r_q3      <= r_q2;
            r_r2_3    <= {{(R2_W-P1_W){1'b0}}, r_p1_2}
                       * {{(R2_W-TEMP_W){1'b0}}, r_d2};
            r_stored3 <= r_stored2;
        end else if (hit3) begin
            r_pack3   <= o_wr.data;
        end
    end

    // combine melt terms, Q.24 back to Q.0
    assign msum = {{(SUM_W-Q_W-16){1'b0}}, r_q3, 16'd0} + {1'b0, r_r2_3};

    // stage 4 (holds only while the output stalls, so no write then)
    always_ff @(posedge i_clk) begin
        if (mv3) begin
            r_cell4   <= r_cell3;
            r_inr4    <= r_inr3;
            r_cold4   <= r_cold3;
            r_warm4   <= r_warm3;
            r_precip4 <= r_precip3;
            r_pack4   <= hit3 ? o_wr.data : r_pack3;
            r_msum4   <= msum[SUM_W-1:24];
            r_stored4 <= r_stored3;
        end
    end

    // resolve snowpack, melt and water
    always_comb begin
        pack_ext  = {{(M_W-WATER_W){1'b0}}, r_pack4};
        sum_c     = {1'b0, r_pack4} + {{(WATER_W+1-PRECIP_W){1'b0}}, r_stored4};
        melt_c    = (r_msum4 > pack_ext) ? r_pack4 : r_msum4[WATER_W-1:0];
        sum_w     = {{(WATER_W+1-PRECIP_W){1'b0}}, r_precip4} + {1'b0, melt_c};
        priority if (r_cold4) begin
            pack_new  = sum_c[WATER_W] ? '1 : sum_c[WATER_W-1:0];
            melt_new  = '0;
            water_new = {{(WATER_W-PRECIP_W){1'b0}}, r_precip4 - r_stored4};
        end else if (r_warm4) begin
            pack_new  = r_pack4 - melt_c;
            melt_new  = melt_c;
            water_new = sum_w[WATER_W] ? '1 : sum_w[WATER_W-1:0];
        end else begin
            pack_new  = r_pack4;
            melt_new  = '0;
            water_new = {{(WATER_W-PRECIP_W){1'b0}}, r_precip4};
        end
    end

    // write-back only for cells inside the grid
    always_comb begin
        o_wr.en      = mv4 && r_inr4;
        o_wr.cell_id = r_cell4;
        o_wr.data    = pack_new;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (mv4) begin
            r_o_cell  <= r_cell4;
            r_o_melt  <= melt_new;
            r_o_pack  <= pack_new;
            r_o_water <= water_new;
        end
    end

    assign o_out_valid  = r_ov;
    assign o_cell_out   = r_o_cell;
    assign o_snow_melt  = r_o_melt;
    assign o_snowpack   = r_o_pack;
    assign o_precip_out = r_o_water;

endmodule
